// File: src/lbkv_pkg.sv
// Package for the log block key/value parser.
// Holds the queue item type, the parse phase type and the role and status codes.
// No dependencies.
package lbkv_pkg;

   // Short queue between the front and the back; depth must be a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [7:0]  PAD_BYTE        = 8'hFF;
   localparam logic [31:0] VERSION_DEFAULT = 32'd2001;

   // Byte roles as reported on the result channel.
   localparam logic [2:0] ROLE_HEADER = 3'd0;
   localparam logic [2:0] ROLE_KLEN   = 3'd1;
   localparam logic [2:0] ROLE_KEY    = 3'd2;
   localparam logic [2:0] ROLE_VLEN   = 3'd3;
   localparam logic [2:0] ROLE_VALUE  = 3'd4;
   localparam logic [2:0] ROLE_PAD    = 3'd5;

   // Sticky block status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_VERSION = 2'd1;
   localparam logic [1:0] ST_TRUNC   = 2'd2;
   localparam logic [1:0] ST_PADDING = 2'd3;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_KLEN   = 3'd1,
      PH_KEY    = 3'd2,
      PH_VLEN   = 3'd3,
      PH_VALUE  = 3'd4,
      PH_PAD    = 3'd5
   } phase_type;

   // One input byte after classification by the front.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_pad;
   } item_type;

   // Queue occupancy flags.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: src/lbkv_front.sv
// Front of the log block key/value parser: accepts input beats and classifies each byte.
// Depends on lbkv_pkg.
module lbkv_front import lbkv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // block_end
   input  qstat_type  q_stat,
   output logic       push,
   output item_type   push_item
);

   logic pad_seen_ff;
   logic pad_seen_in;

   assign req_tready = ~q_stat.full;
   assign push       = req_tvalid & req_tready;

   always_comb begin
      push_item.data   = req_tdata;
      push_item.last   = req_tlast;
      push_item.is_pad = (req_tdata == PAD_BYTE);
   end

   // Tracks whether the current block has carried a pad byte; cleared at block end.
   always_comb begin
      pad_seen_in = pad_seen_ff;
      if (push) begin
         pad_seen_in = req_tlast ? 1'b0 : (pad_seen_ff | push_item.is_pad);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_seen_ff <= 1'b0;
      end else begin
         pad_seen_ff <= pad_seen_in;
      end
   end

endmodule

// File: src/lbkv_queue.sv
// Short FIFO between the front and the back of the log block key/value parser.
// Depends on lbkv_pkg.
module lbkv_queue import lbkv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output item_type  head_item,
   output qstat_type q_stat
);

   item_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign head_item    = entries_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/lbkv_back.sv
// Back of the log block key/value parser: per-byte parse state update and result register.
// Depends on lbkv_pkg.
module lbkv_back import lbkv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] expected_version,
   input  item_type    head_item,
   input  qstat_type   q_stat,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] byte_role, [3] field_end, [5:4] status, [7:6] zero
   output logic        rsp_tlast    // block_done
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  biw_ff, biw_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] left_ff, left_in;
   logic [1:0]  err_ff, err_in;

   logic        valid_ff, valid_in;
   logic [2:0]  role_ff, role_in;
   logic        fend_ff, fend_in;
   logic [1:0]  status_ff, status_in;
   logic        done_ff;

   assign pop = ~q_stat.empty & (~valid_ff | rsp_tready);

   always_comb begin
      logic [31:0] hdr_word;
      logic [31:0] len_word;
      logic [31:0] left_dec;
      logic [1:0]  err_v;
      logic        boundary;

      hdr_word = shift_ff;
      case (biw_ff)
         2'd0:    hdr_word = shift_ff | {24'b0, head_item.data};
         2'd1:    hdr_word = shift_ff | {16'b0, head_item.data, 8'b0};
         2'd2:    hdr_word = shift_ff | {8'b0, head_item.data, 16'b0};
         default: hdr_word = shift_ff | {head_item.data, 24'b0};
      endcase
      len_word = {shift_ff[23:0], head_item.data};
      left_dec = left_ff - 32'd1;

      phase_in = phase_ff;
      biw_in   = biw_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      err_v    = err_ff;
      role_in  = ROLE_PAD;
      fend_in  = 1'b0;

      case (phase_ff)
         PH_HEADER: begin
            role_in = ROLE_HEADER;
            if (biw_ff == 2'd3) begin
               fend_in  = 1'b1;
               if (hdr_word != expected_version && err_v == ST_OK) begin
                  err_v = ST_VERSION;
               end
               biw_in   = 2'd0;
               shift_in = '0;
               phase_in = PH_KLEN;
            end else begin
               biw_in   = biw_ff + 2'd1;
               shift_in = hdr_word;
            end
         end
         PH_KLEN, PH_VLEN: begin
            if (phase_ff == PH_KLEN && biw_ff == 2'd0 && head_item.is_pad) begin
               role_in  = ROLE_PAD;
               phase_in = PH_PAD;
            end else begin
               role_in = (phase_ff == PH_KLEN) ? ROLE_KLEN : ROLE_VLEN;
               if (biw_ff == 2'd3) begin
                  fend_in  = 1'b1;
                  left_in  = len_word;
                  shift_in = '0;
                  biw_in   = 2'd0;
                  if (len_word != '0) begin
                     phase_in = (phase_ff == PH_KLEN) ? PH_KEY : PH_VALUE;
                  end else begin
                     phase_in = (phase_ff == PH_KLEN) ? PH_VLEN : PH_KLEN;
                  end
               end else begin
                  biw_in   = biw_ff + 2'd1;
                  shift_in = len_word;
               end
            end
         end
         PH_KEY, PH_VALUE: begin
            role_in = (phase_ff == PH_KEY) ? ROLE_KEY : ROLE_VALUE;
            left_in = left_dec;
            if (left_dec == '0) begin
               fend_in  = 1'b1;
               phase_in = (phase_ff == PH_KEY) ? PH_VLEN : PH_KLEN;
            end
         end
         default: begin
            role_in  = ROLE_PAD;
            phase_in = PH_PAD;
            if (!head_item.is_pad && err_v == ST_OK) begin
               err_v = ST_PADDING;
            end
         end
      endcase

      boundary = (phase_in == PH_PAD) || (phase_in == PH_KLEN && biw_in == 2'd0);
      if (head_item.last && !boundary && err_v == ST_OK) begin
         err_v = ST_TRUNC;
      end
      err_in = err_v;

      // The status shown with a byte is the sticky error after that byte, taken before the
      // block-end clear below.
      status_in = err_v;

      if (head_item.last) begin
         phase_in = PH_HEADER;
         biw_in   = 2'd0;
         shift_in = '0;
         left_in  = '0;
         err_in   = ST_OK;
      end

      valid_in = pop | (valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         biw_ff   <= 2'd0;
         shift_ff <= '0;
         left_ff  <= '0;
         err_ff   <= ST_OK;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            biw_ff   <= biw_in;
            shift_ff <= shift_in;
            left_ff  <= left_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         role_ff   <= role_in;
         fend_ff   <= fend_in;
         status_ff <= status_in;
         done_ff   <= head_item.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, status_ff, fend_ff, role_ff};
   assign rsp_tlast  = done_ff;

endmodule

// File: src/log_block_kv_parser.sv
// Top level of the log block key/value parser: configuration register, front, queue, back.
// Depends on lbkv_pkg, lbkv_front, lbkv_queue and lbkv_back.
//
//   Channel | Direction | Handshake             | Payload
//   req     | in        | req_tvalid/req_tready | tdata[7:0] data_byte, tlast block_end
//   rsp     | out       | rsp_tvalid/rsp_tready | tdata byte_role/field_end/status, tlast
//   csr     | in        | csr_valid/csr_ready   | csr_data expected_version
//
// One byte per clock is sustained while results are taken; the parse state update in the back
// sets that figure. A result is registered: the byte is written to the queue when it is
// accepted, and the result register loads when the back pops the byte from the queue.
// Synchronous reset clears the queue, parse state and output valid, and sets the expected
// version to 2001. Either side may stall on its own: the two-entry queue and the result
// register take input beats while a finished result waits to be taken, until the queue fills.
module log_block_kv_parser import lbkv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // block_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] byte_role, [3] field_end, [5:4] status, [7:6] zero
   output logic        rsp_tlast,   // block_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // expected_version
);

   logic [31:0] version_ff;
   logic [31:0] version_in;
   logic        push;
   logic        pop;
   item_type    push_item;
   item_type    head_item;
   qstat_type   q_stat;

   // Takes every write unchecked; the user must write only while the block is idle.
   assign csr_ready  = 1'b1;
   assign version_in = (csr_valid && csr_ready) ? csr_data : version_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_DEFAULT;
      end else begin
         version_ff <= version_in;
      end
   end

   // The front takes beats while the queue has room and tags pad bytes.
   lbkv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_stat     (q_stat),
      .push       (push),
      .push_item  (push_item)
   );

   lbkv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   // The back pops a byte whenever its result register is free or being drained.
   lbkv_back u_back (
      .clock            (clock),
      .reset            (reset),
      .expected_version (version_ff),
      .head_item        (head_item),
      .q_stat           (q_stat),
      .pop              (pop),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast)
   );

`ifndef SYNTHESIS
   // A block that ends on a header, key or value byte that does not close its field
   // must report an error.
   a_trunc_flagged: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast && !rsp_tdata[3] &&
       (rsp_tdata[2:0] == ROLE_HEADER || rsp_tdata[2:0] == ROLE_KEY ||
        rsp_tdata[2:0] == ROLE_VALUE)) |-> (rsp_tdata[5:4] != ST_OK))
      else $error("block ended inside a field without an error status");

   // Padding bytes never close a field.
   a_pad_no_fend: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == ROLE_PAD) |-> !rsp_tdata[3])
      else $error("padding byte marked as field end");

   // The queue cannot be full and empty at once.
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty together");
`endif

endmodule

// File: tb/tb_log_block_kv_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for log_block_kv_parser: directed and random log blocks with
// byte-role prediction and random stalls on both streams. Depends on lbkv_pkg and the RTL.
module tb_log_block_kv_parser;
   import lbkv_pkg::*;

   // The watchdog limit covers the longest correct quiet stretch: the long receiver hold,
   // a drain before a register write and the idle bursts, with a wide margin on top.
   localparam int QUIET_LIMIT    = 2000;
   localparam int HOLD_CYCLES    = 150;
   localparam int PHASE_BEATS    = 300;
   localparam int SETTING_COUNT  = 6;
   localparam int DIRECTED_ROWS  = 26;
   localparam int MAX_REPORTS    = 10;
   localparam int SETTLE_CYCLES  = 4;

   // One expected result beat, one field per member.
   typedef struct packed {
      logic [2:0] role;
      logic       fend;
      logic [1:0] status;
      logic       done;
   } byte_tag_type;

   // One row of the directed table. Where given is set, the tag is the typed-in answer;
   // otherwise the predictor supplies it.
   typedef struct packed {
      logic [7:0]   data;
      logic         last;
      logic         given;
      byte_tag_type tag;
   } dir_row_type;

   localparam byte_tag_type NO_TAG = '0;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tlast;    // block_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [2:0] byte_role, [3] field_end, [5:4] status, [7:6] zero
   logic        rsp_tlast;    // block_done
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;     // expected_version

   log_block_kv_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // The clock runs high then low, 10 ns per period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of the parse state and of the version register.
   phase_type   pr_phase;
   logic [1:0]  pr_pos;
   logic [31:0] pr_word;
   logic [31:0] pr_left;
   logic [1:0]  pr_err;
   logic [31:0] cur_version;

   // Tags still owed by the block, oldest first.
   byte_tag_type pending_tags[$];
   logic [7:0]   block_bytes[$];
   dir_row_type  dir_rows [0:DIRECTED_ROWS-1];

   int  mismatches;
   int  results_seen;
   int  faulted_results;
   int  beats_sent;
   int  blocks_sent;
   int  settings_used;
   int  quiet_cycles;
   bit  hold_req;
   bit  no_idle;
   int  gap_pct;

   // Only the first error of a block is kept; later ones are dropped.
   task automatic flag_fault(input logic [1:0] code);
      if (pr_err == ST_OK) pr_err = code;
   endtask

   // Works out the tag of one accepted byte and advances the predicted parse state.
   task automatic tag_byte(input logic [7:0] b, input logic last, output byte_tag_type t);
      logic [2:0] role;
      logic       fend;
      role = ROLE_PAD;
      fend = 1'b0;
      case (pr_phase)
         PH_HEADER: begin
            // The version word arrives little-endian.
            role = ROLE_HEADER;
            pr_word = pr_word | ({24'd0, b} << (8 * pr_pos));
            if (pr_pos == 2'd3) begin
               fend = 1'b1;
               if (pr_word != cur_version) flag_fault(ST_VERSION);
               pr_pos = 2'd0;
               pr_word = 32'd0;
               pr_phase = PH_KLEN;
            end else begin
               pr_pos = pr_pos + 2'd1;
            end
         end
         PH_KLEN, PH_VLEN: begin
            if (pr_phase == PH_KLEN && pr_pos == 2'd0 && b == PAD_BYTE) begin
               // A record that would open with the pad byte starts the padding instead.
               role = ROLE_PAD;
               pr_phase = PH_PAD;
            end else begin
               role = (pr_phase == PH_KLEN) ? ROLE_KLEN : ROLE_VLEN;
               pr_word = {pr_word[23:0], b};
               if (pr_pos == 2'd3) begin
                  fend = 1'b1;
                  pr_left = pr_word;
                  pr_word = 32'd0;
                  pr_pos = 2'd0;
                  // An empty key or value skips straight to the following length.
                  if (pr_left != 32'd0)
                     pr_phase = (pr_phase == PH_KLEN) ? PH_KEY : PH_VALUE;
                  else
                     pr_phase = (pr_phase == PH_KLEN) ? PH_VLEN : PH_KLEN;
               end else begin
                  pr_pos = pr_pos + 2'd1;
               end
            end
         end
         PH_KEY, PH_VALUE: begin
            role = (pr_phase == PH_KEY) ? ROLE_KEY : ROLE_VALUE;
            pr_left = pr_left - 32'd1;
            if (pr_left == 32'd0) begin
               fend = 1'b1;
               pr_phase = (pr_phase == PH_KEY) ? PH_VLEN : PH_KLEN;
            end
         end
         default: begin
            role = ROLE_PAD;
            pr_phase = PH_PAD;
            if (b != PAD_BYTE) flag_fault(ST_PADDING);
         end
      endcase
      // A block may only end inside padding or right after a whole header or record.
      if (last && !(pr_phase == PH_PAD || (pr_phase == PH_KLEN && pr_pos == 2'd0)))
         flag_fault(ST_TRUNC);
      t = {role, fend, pr_err, last};
      if (last) begin
         pr_phase = PH_HEADER;
         pr_pos = 2'd0;
         pr_word = 32'd0;
         pr_left = 32'd0;
         pr_err = ST_OK;
      end
   endtask

   // Appends one tag to the list of owed results.
   task automatic owe_tag(input byte_tag_type t);
      pending_tags = {pending_tags, t};
   endtask

   // Appends one byte to the block being composed.
   task automatic add_byte(input logic [7:0] b);
      block_bytes = {block_bytes, b};
   endtask

   // Offers one beat and waits for the handshake. Called and left at a falling edge;
   // tvalid stays high so that back-to-back beats need no second assignment.
   task automatic send_beat(input logic [7:0] b, input logic last,
                            input byte_tag_type given_tag, input bit use_given);
      byte_tag_type pred;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      tag_byte(b, last, pred);
      owe_tag(use_given ? given_tag : pred);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Stops offering beats until every owed result has come back, then lets the pipeline settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_tags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_version(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      cur_version = value;
      settings_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Key and value lengths are mostly small, sometimes zero, and now and then a raw
   // 32-bit word that the block cannot hold.
   function automatic logic [31:0] pick_len();
      int r;
      r = $urandom_range(0, 15);
      if (r < 4) return 32'd0;
      if (r < 14) return $urandom_range(1, 8);
      if (r < 15) return $urandom_range(9, 40);
      return $urandom;
   endfunction

   // Builds one block in block_bytes. Most blocks are well formed with random content;
   // the rest carry a wrong version, a cut-off tail, stray padding or plain noise.
   task automatic compose_block();
      int          kind;
      int          fields;
      int          ending;
      int          cut;
      int          n;
      int          i;
      int          f;
      bit          stop;
      logic [31:0] ver;
      logic [31:0] flen;
      block_bytes.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         cut = $urandom_range(1, 24);
         repeat (cut) add_byte(8'($urandom_range(0, 255)));
      end else begin
         ver = cur_version;
         if ($urandom_range(0, 7) == 0)
            ver = $urandom_range(0, 1) ? $urandom : ver ^ (32'd1 << $urandom_range(0, 31));
         for (i = 0; i < 4; i++) add_byte(ver[8*i +: 8]);
         fields = 2 * $urandom_range(0, 4);
         stop = 1'b0;
         for (f = 0; f < fields && !stop; f++) begin
            flen = pick_len();
            for (i = 3; i >= 0; i--) add_byte(flen[8*i +: 8]);
            if (flen > 32'd40) begin
               // Too long to send in full: the block ends inside the field.
               repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
               stop = 1'b1;
            end else begin
               repeat (flen) add_byte(8'($urandom_range(0, 255)));
            end
         end
         if (!stop) begin
            ending = $urandom_range(0, 3);
            if (ending == 1) begin
               cut = $urandom_range(1, 6);
               repeat (cut) add_byte(PAD_BYTE);
               n = block_bytes.size();
               if ($urandom_range(0, 3) == 0)
                  block_bytes[$urandom_range(n - cut, n - 1)] = 8'($urandom_range(0, 255));
            end else if (ending == 2 && block_bytes.size() > 1) begin
               n = block_bytes.size() - 1;
               cut = $urandom_range(1, (n < 6) ? n : 6);
               repeat (cut) void'(block_bytes.pop_back());
            end
         end
      end
   endtask

   // Sends the composed block, with random sender gaps unless the quiet tail is on.
   task automatic send_block();
      int i;
      for (i = 0; i < block_bytes.size(); i++) begin
         if (!no_idle && $urandom_range(0, 99) < gap_pct) idle_sender($urandom_range(1, 18));
         send_beat(block_bytes[i], i == block_bytes.size() - 1, NO_TAG, 1'b0);
      end
      blocks_sent++;
   endtask

   // Receiver: alternates runs of ready with stall bursts, and once holds off for a long
   // stretch so that the queue fills and the input stalls.
   initial begin
      int left;
      bit stall;
      rsp_tready = 1'b0;
      left = 0;
      stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
            left = 0;
         end else begin
            if (left == 0) begin
               stall = !no_idle && ($urandom_range(0, 2) == 0);
               left = stall ? $urandom_range(1, 18) : $urandom_range(1, 40);
            end
            rsp_tready <= !stall;
            left--;
         end
      end
   end

   // Result checker: each result beat is compared with the oldest owed tag.
   always @(posedge clock) begin
      byte_tag_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tdata[5:4] != ST_OK) faulted_results++;
         if (pending_tags.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result beat: tdata %h tlast %b", rsp_tdata, rsp_tlast);
         end else begin
            want = pending_tags.pop_front();
            if (rsp_tdata[2:0] != want.role || rsp_tdata[3] != want.fend ||
                rsp_tdata[5:4] != want.status || rsp_tdata[7:6] != 2'b00 ||
                rsp_tlast != want.done) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"result %0d (exp/got): role %0d/%0d field_end %b/%b ",
                            "status %0d/%0d done %b/%b pad bits %b"},
                           results_seen, want.role, rsp_tdata[2:0], want.fend, rsp_tdata[3],
                           want.status, rsp_tdata[5:4], want.done, rsp_tlast,
                           rsp_tdata[7:6]);
            end
         end
      end
   end

   // Watchdog: ends the run if no beat moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles, %0d results owed",
                  quiet_cycles, pending_tags.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [31:0] settings [0:SETTING_COUNT-1];
      int          p;
      int          r;
      int          phase_start;
      bit          hold_issued;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_data = 32'd0;
      hold_req = 1'b0;
      no_idle = 1'b0;
      hold_issued = 1'b0;
      gap_pct = 10;
      mismatches = 0;
      results_seen = 0;
      faulted_results = 0;
      beats_sent = 0;
      blocks_sent = 0;
      settings_used = 1;
      quiet_cycles = 0;
      cur_version = VERSION_DEFAULT;
      pr_phase = PH_HEADER;
      pr_pos = 2'd0;
      pr_word = 32'd0;
      pr_left = 32'd0;
      pr_err = ST_OK;

      // Register settings of the random phases, extremes included. The directed part
      // runs on the reset value.
      settings[0] = 32'h0000_0000;
      settings[1] = 32'hFFFF_FFFF;
      settings[2] = $urandom;
      settings[3] = VERSION_DEFAULT;
      settings[4] = $urandom;
      settings[5] = 32'h8000_0001;

      // Directed blocks, all against the reset version 2001 (header bytes D1 07 00 00).
      // A: a good record with a one-byte key of 00 and a one-byte value of FF.
      // B: a wrong version word, then a cut-off length; the version error must win.
      // C: padding that turns bad on the last byte.
      // D: a block that ends inside its header.
      dir_rows = '{
         {8'hD1, 1'b0, 1'b1, ROLE_HEADER, 1'b0, ST_OK, 1'b0},
         {8'h07, 1'b0, 1'b1, ROLE_HEADER, 1'b0, ST_OK, 1'b0},
         {8'h00, 1'b0, 1'b1, ROLE_HEADER, 1'b0, ST_OK, 1'b0},
         {8'h00, 1'b0, 1'b1, ROLE_HEADER, 1'b1, ST_OK, 1'b0},
         {8'h00, 1'b0, 1'b0, NO_TAG},
         {8'h00, 1'b0, 1'b0, NO_TAG},
         {8'h00, 1'b0, 1'b0, NO_TAG},
         {8'h01, 1'b0, 1'b0, NO_TAG},
         {8'h00, 1'b0, 1'b0, NO_TAG},
         {8'h00, 1'b0, 1'b0, NO_TAG},
         {8'h00, 1'b0, 1'b0, NO_TAG},
         {8'h00, 1'b0, 1'b0, NO_TAG},
         {8'h01, 1'b0, 1'b0, NO_TAG},
         {8'hFF, 1'b1, 1'b0, NO_TAG},
         {8'hFF, 1'b0, 1'b1, ROLE_HEADER, 1'b0, ST_OK, 1'b0},
         {8'hFF, 1'b0, 1'b1, ROLE_HEADER, 1'b0, ST_OK, 1'b0},
         {8'hFF, 1'b0, 1'b1, ROLE_HEADER, 1'b0, ST_OK, 1'b0},
         {8'hFF, 1'b0, 1'b1, ROLE_HEADER, 1'b1, ST_VERSION, 1'b0},
         {8'h00, 1'b1, 1'b1, ROLE_KLEN, 1'b0, ST_VERSION, 1'b1},
         {8'hD1, 1'b0, 1'b0, NO_TAG},
         {8'h07, 1'b0, 1'b0, NO_TAG},
         {8'h00, 1'b0, 1'b0, NO_TAG},
         {8'h00, 1'b0, 1'b0, NO_TAG},
         {8'hFF, 1'b0, 1'b1, ROLE_PAD, 1'b0, ST_OK, 1'b0},
         {8'h00, 1'b1, 1'b1, ROLE_PAD, 1'b0, ST_PADDING, 1'b1},
         {8'hD1, 1'b1, 1'b1, ROLE_HEADER, 1'b0, ST_TRUNC, 1'b1}
      };

      // Reset is held high at the start and released at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (r = 0; r < DIRECTED_ROWS; r++) begin
         if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 18));
         send_beat(dir_rows[r].data, dir_rows[r].last, dir_rows[r].tag, dir_rows[r].given);
         if (dir_rows[r].last) blocks_sent++;
      end

      // Random phases, one register setting each. Every write waits for the block to
      // go idle; the final phase runs with no idling on either side.
      for (p = 0; p < SETTING_COUNT; p++) begin
         drain_results();
         write_version(settings[p]);
         no_idle = (p == SETTING_COUNT - 1);
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BEATS) begin
            case ($urandom_range(0, 3))
               0:       gap_pct = 0;
               1:       gap_pct = 5;
               2:       gap_pct = 15;
               default: gap_pct = 30;
            endcase
            // Partway through the second phase the receiver stops taking results for a
            // long stretch while beats keep being offered.
            if (p == 1 && !hold_issued && beats_sent - phase_start >= 100) begin
               hold_req = 1'b1;
               hold_issued = 1'b1;
               gap_pct = 0;
            end
            compose_block();
            send_block();
         end
      end

      // Let every owed result come back, then keep watching for strays.
      req_tvalid <= 1'b0;
      while (pending_tags.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d beats in %0d blocks under %0d version settings.",
               beats_sent, blocks_sent, settings_used);
      $display("Checked %0d results, %0d of them with an error status; %0d mismatches.",
               results_seen, faulted_results, mismatches);
      if (mismatches == 0 && pending_tags.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
